/* rtl/csb_pkg.sv */
// Shared constants for the column spread strip bounds block.
// Used by csb_front, csb_back, the top level and the testbench; depends on nothing.
`default_nettype none

package csb_pkg;

   localparam int DEFAULT_MAX_COLUMNS = 1024;
   localparam int DEFAULT_MAX_ROWS    = 256;

   localparam int PIXEL_WIDTH        = 8;
   localparam int EDGE_WIDTH         = 10;
   localparam int COLUMN_COUNT_WIDTH = 11;
   localparam int ROW_COUNT_WIDTH    = 9;
   localparam int CSR_INDEX_WIDTH    = 2;
   localparam int CSR_DATA_WIDTH     = 11;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COLUMN_COUNT = CSR_INDEX_WIDTH'(0);
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ROW_COUNT    = CSR_INDEX_WIDTH'(1);

   localparam logic [COLUMN_COUNT_WIDTH-1:0] COLUMN_COUNT_RESET = COLUMN_COUNT_WIDTH'(1024);
   localparam logic [ROW_COUNT_WIDTH-1:0]    ROW_COUNT_RESET    = ROW_COUNT_WIDTH'(20);

   localparam int MIN_BAND_ROWS    = 20;
   localparam int FLAT_RUN_TO_STOP = 25;
   localparam int THRESHOLD_SHIFT  = 4;
   localparam int QUEUE_DEPTH      = 4;

endpackage

`default_nettype wire

/* rtl/csb_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module csb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/csb_queue.sv */
// Short first-in first-out queue between the front and back parts.
// Depends on nothing; depth must be a power of two.
`default_nettype none

module csb_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] pop_data,
   output logic                  empty
);

   localparam int PW = $clog2(DEPTH);
   localparam int NW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slots_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0]    count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + NW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign full     = (count_ff == NW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = slots_ff[rd_ptr_ff];

endmodule

`default_nettype wire

/* rtl/csb_front.sv */
// Front part: configuration registers, pixel intake and column/row tracking.
// Each accepted pixel is tagged with its column, first-row and band-end marks.
// Depends on csb_pkg.
`default_nettype none

module csb_front
   import csb_pkg::*;
#(
   parameter int MAX_COLUMNS = DEFAULT_MAX_COLUMNS,
   parameter int MAX_ROWS    = DEFAULT_MAX_ROWS,
   localparam int XW = $clog2(MAX_COLUMNS),
   localparam int CW = $clog2(MAX_COLUMNS + 1),
   localparam int RW = $clog2(MAX_ROWS),
   localparam int HW = $clog2(MAX_ROWS + 1),
   localparam int EW = HW + 2 + XW + PIXEL_WIDTH
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic [PIXEL_WIDTH-1:0]     req_pixel,
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]  csr_wdata,
   output logic      [CW-1:0]              cols,
   output logic                            q_push,
   output logic      [EW-1:0]              q_data,
   input  wire logic                       q_full
);

   localparam int CCW = (CW > COLUMN_COUNT_WIDTH) ? CW : COLUMN_COUNT_WIDTH;
   localparam int RCW = (HW > ROW_COUNT_WIDTH) ? HW : ROW_COUNT_WIDTH;

   logic [COLUMN_COUNT_WIDTH-1:0] column_count_ff, column_count_in;
   logic [ROW_COUNT_WIDTH-1:0]    row_count_ff, row_count_in;
   logic [XW-1:0]                 col_ff, col_in;
   logic [RW-1:0]                 row_ff, row_in;

   logic [CCW-1:0] col_reg_w;
   logic [RCW-1:0] row_reg_w;
   logic [CW-1:0]  cols_w;
   logic [HW-1:0]  rows_w;
   logic [CW-1:0]  col_next;
   logic [HW-1:0]  done_rows;
   logic           accept;
   logic           row_end;
   logic           band_end;

   always_comb begin
      col_reg_w = CCW'(column_count_ff);
      row_reg_w = RCW'(row_count_ff);
      if (col_reg_w == '0) begin
         cols_w = CW'(1);
      end else if (col_reg_w > CCW'(MAX_COLUMNS)) begin
         cols_w = CW'(MAX_COLUMNS);
      end else begin
         cols_w = CW'(col_reg_w);
      end
      if (row_reg_w == '0) begin
         rows_w = HW'(1);
      end else if (row_reg_w > RCW'(MAX_ROWS)) begin
         rows_w = HW'(MAX_ROWS);
      end else begin
         rows_w = HW'(row_reg_w);
      end

      accept    = req_valid && !q_full;
      col_next  = CW'(col_ff) + CW'(1);
      row_end   = (col_next >= cols_w);
      done_rows = HW'(row_ff) + HW'(1);
      band_end  = row_end && (done_rows >= rows_w);

      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (row_end) begin
            col_in = '0;
            row_in = band_end ? '0 : RW'(done_rows);
         end else begin
            col_in = XW'(col_next);
         end
      end

      column_count_in = column_count_ff;
      row_count_in    = row_count_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_COLUMN_COUNT: begin
               column_count_in = COLUMN_COUNT_WIDTH'(csr_wdata);
            end
            CSR_ROW_COUNT: begin
               row_count_in = csr_wdata[ROW_COUNT_WIDTH-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= COLUMN_COUNT_RESET;
         row_count_ff    <= ROW_COUNT_RESET;
         col_ff          <= '0;
         row_ff          <= '0;
      end else begin
         column_count_ff <= column_count_in;
         row_count_ff    <= row_count_in;
         col_ff          <= col_in;
         row_ff          <= row_in;
      end
   end

   assign req_ready = !q_full;
   assign csr_ready = 1'b1;
   assign cols      = cols_w;
   assign q_push    = accept;
   assign q_data    = {done_rows, band_end, (row_ff == '0), col_ff, req_pixel};

endmodule

`default_nettype wire

/* rtl/csb_back.sv */
// Back part: per-column accumulation in RAM, then the two-pass column scan
// for the peak and the strip edges, and the result register.
// Depends on csb_pkg and csb_ram.
`default_nettype none

module csb_back
   import csb_pkg::*;
#(
   parameter int MAX_COLUMNS = DEFAULT_MAX_COLUMNS,
   parameter int MAX_ROWS    = DEFAULT_MAX_ROWS,
   localparam int XW = $clog2(MAX_COLUMNS),
   localparam int CW = $clog2(MAX_COLUMNS + 1),
   localparam int HW = $clog2(MAX_ROWS + 1),
   localparam int EW = HW + 2 + XW + PIXEL_WIDTH
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [CW-1:0]         cols,
   input  wire logic [EW-1:0]         q_data,
   input  wire logic                  q_empty,
   output logic                       q_pop,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic                       rsp_found,
   output logic      [EDGE_WIDTH-1:0] rsp_left_edge,
   output logic      [EDGE_WIDTH-1:0] rsp_right_edge
);

   localparam int RW  = $clog2(MAX_ROWS);
   localparam int SW  = PIXEL_WIDTH + RW;
   localparam int SQW = 2 * PIXEL_WIDTH + RW;
   localparam int MW  = SW + SQW;
   localparam int VW  = HW + SQW;
   localparam int AVW = VW + THRESHOLD_SHIFT;
   localparam int FW  = $clog2(FLAT_RUN_TO_STOP + 1);

   typedef enum logic [1:0] {
      ST_ACCUM,
      ST_PEAK,
      ST_EDGE,
      ST_REPORT
   } state_type;

   state_type state_ff, state_in;

   logic [PIXEL_WIDTH-1:0] e_pixel;
   logic [XW-1:0]          e_col;
   logic                   e_first;
   logic                   e_last;
   logic [HW-1:0]          e_height;

   logic                   b_valid_ff, b_valid_in;
   logic [PIXEL_WIDTH-1:0] b_pixel_ff, b_pixel_in;
   logic [XW-1:0]          b_col_ff, b_col_in;
   logic                   b_first_ff, b_first_in;

   logic                   w_valid_ff, w_valid_in;
   logic [XW-1:0]          w_addr_ff, w_addr_in;
   logic [MW-1:0]          w_data_ff, w_data_in;

   logic [HW-1:0]          height_ff, height_in;
   logic                   issue_on_ff, issue_on_in;
   logic [XW-1:0]          issue_x_ff, issue_x_in;
   logic                   r_valid_ff, r_valid_in;
   logic [XW-1:0]          r_x_ff, r_x_in;
   logic                   p_valid_ff, p_valid_in;
   logic [XW-1:0]          p_x_ff, p_x_in;
   logic [VW-1:0]          prod_a_ff, prod_a_in;
   logic [VW-1:0]          prod_b_ff, prod_b_in;
   logic                   v_valid_ff, v_valid_in;
   logic [XW-1:0]          v_x_ff, v_x_in;
   logic [VW-1:0]          v_ff, v_in;

   logic [VW-1:0]          peak_ff, peak_in;
   logic                   have_left_ff, have_left_in;
   logic                   stopped_ff, stopped_in;
   logic [FW-1:0]          flat_ff, flat_in;
   logic [XW-1:0]          left_ff, left_in;
   logic [XW-1:0]          right_ff, right_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   found_ff, found_in;
   logic [EDGE_WIDTH-1:0]  left_edge_ff, left_edge_in;
   logic [EDGE_WIDTH-1:0]  right_edge_ff, right_edge_in;

   logic                   pop;
   logic                   issue;
   logic [MW-1:0]          rd_data;
   logic [XW-1:0]          rd_addr;
   logic [MW-1:0]          base;
   logic [2*PIXEL_WIDTH-1:0] pix_ext;
   logic [2*PIXEL_WIDTH-1:0] pix_sq;
   logic [SW-1:0]          new_sum;
   logic [SQW-1:0]         new_sq;
   logic [MW-1:0]          wr_data;
   logic                   issue_last;
   logic                   v_last;
   logic                   active;
   logic                   found_w;

   csb_ram #(
      .WIDTH (MW),
      .DEPTH (MAX_COLUMNS)
   ) u_column_ram (
      .clock   (clock),
      .wr_en   (b_valid_ff),
      .wr_addr (b_col_ff),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      {e_height, e_last, e_first, e_col, e_pixel} = q_data;

      pop = (state_ff == ST_ACCUM) && !q_empty;

      b_valid_in = pop;
      b_pixel_in = e_pixel;
      b_col_in   = e_col;
      b_first_in = e_first;

      base    = (w_valid_ff && (w_addr_ff == b_col_ff)) ? w_data_ff : rd_data;
      pix_ext = (2*PIXEL_WIDTH)'(b_pixel_ff);
      pix_sq  = pix_ext * pix_ext;
      if (b_first_ff) begin
         new_sum = SW'(b_pixel_ff);
         new_sq  = SQW'(pix_sq);
      end else begin
         new_sum = base[MW-1:SQW] + SW'(b_pixel_ff);
         new_sq  = base[SQW-1:0] + SQW'(pix_sq);
      end
      wr_data = {new_sum, new_sq};

      w_valid_in = b_valid_ff;
      w_addr_in  = b_col_ff;
      w_data_in  = wr_data;

      issue      = ((state_ff == ST_PEAK) || (state_ff == ST_EDGE)) && issue_on_ff
                   && !b_valid_ff;
      issue_last = ((CW'(issue_x_ff) + CW'(1)) == cols);
      rd_addr    = (state_ff == ST_ACCUM) ? e_col : issue_x_ff;

      issue_on_in = issue_on_ff;
      issue_x_in  = issue_x_ff;
      if (issue) begin
         if (issue_last) begin
            issue_on_in = 1'b0;
         end else begin
            issue_x_in = issue_x_ff + XW'(1);
         end
      end

      r_valid_in = issue;
      r_x_in     = issue_x_ff;

      p_valid_in = r_valid_ff;
      p_x_in     = r_x_ff;
      prod_a_in  = VW'(height_ff) * VW'(rd_data[SQW-1:0]);
      prod_b_in  = VW'(rd_data[MW-1:SQW]) * VW'(rd_data[MW-1:SQW]);

      v_valid_in = p_valid_ff;
      v_x_in     = p_x_ff;
      v_in       = (prod_a_ff > prod_b_ff) ? (prod_a_ff - prod_b_ff) : '0;

      v_last = ((CW'(v_x_ff) + CW'(1)) == cols);
      active = ((AVW'(v_ff) << THRESHOLD_SHIFT) > AVW'(peak_ff));

      found_w = have_left_ff && (height_ff >= HW'(MIN_BAND_ROWS)) && (right_ff > left_ff);

      state_in      = state_ff;
      height_in     = height_ff;
      peak_in       = peak_ff;
      have_left_in  = have_left_ff;
      stopped_in    = stopped_ff;
      flat_in       = flat_ff;
      left_in       = left_ff;
      right_in      = right_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      found_in      = found_ff;
      left_edge_in  = left_edge_ff;
      right_edge_in = right_edge_ff;

      case (state_ff)
         ST_ACCUM: begin
            if (pop && e_last) begin
               state_in    = ST_PEAK;
               height_in   = e_height;
               issue_on_in = 1'b1;
               issue_x_in  = '0;
               peak_in     = '0;
            end
         end
         ST_PEAK: begin
            if (v_valid_ff) begin
               if (v_ff > peak_ff) begin
                  peak_in = v_ff;
               end
               if (v_last) begin
                  state_in     = ST_EDGE;
                  issue_on_in  = 1'b1;
                  issue_x_in   = '0;
                  have_left_in = 1'b0;
                  stopped_in   = 1'b0;
                  flat_in      = '0;
                  left_in      = '0;
                  right_in     = '0;
               end
            end
         end
         ST_EDGE: begin
            if (v_valid_ff) begin
               if (!have_left_ff) begin
                  if (active) begin
                     have_left_in = 1'b1;
                     left_in      = v_x_ff;
                     right_in     = v_x_ff;
                  end
               end else if (!stopped_ff) begin
                  if (active) begin
                     right_in = v_x_ff;
                     flat_in  = '0;
                  end else if (flat_ff == FW'(FLAT_RUN_TO_STOP)) begin
                     stopped_in = 1'b1;
                  end else begin
                     flat_in = flat_ff + FW'(1);
                  end
               end
               if (v_last) begin
                  state_in = ST_REPORT;
               end
            end
         end
         ST_REPORT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               found_in      = found_w;
               left_edge_in  = found_w ? EDGE_WIDTH'(left_ff) : '0;
               right_edge_in = found_w ? EDGE_WIDTH'(right_ff) : '0;
               state_in      = ST_ACCUM;
            end
         end
         default: begin
            state_in = ST_ACCUM;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      b_pixel_ff    <= b_pixel_in;
      b_col_ff      <= b_col_in;
      b_first_ff    <= b_first_in;
      w_addr_ff     <= w_addr_in;
      w_data_ff     <= w_data_in;
      height_ff     <= height_in;
      issue_x_ff    <= issue_x_in;
      r_x_ff        <= r_x_in;
      p_x_ff        <= p_x_in;
      prod_a_ff     <= prod_a_in;
      prod_b_ff     <= prod_b_in;
      v_x_ff        <= v_x_in;
      v_ff          <= v_in;
      have_left_ff  <= have_left_in;
      stopped_ff    <= stopped_in;
      flat_ff       <= flat_in;
      left_ff       <= left_in;
      right_ff      <= right_in;
      found_ff      <= found_in;
      left_edge_ff  <= left_edge_in;
      right_edge_ff <= right_edge_in;
      if (reset) begin
         state_ff     <= ST_ACCUM;
         b_valid_ff   <= 1'b0;
         w_valid_ff   <= 1'b0;
         issue_on_ff  <= 1'b0;
         r_valid_ff   <= 1'b0;
         p_valid_ff   <= 1'b0;
         v_valid_ff   <= 1'b0;
         peak_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         b_valid_ff   <= b_valid_in;
         w_valid_ff   <= w_valid_in;
         issue_on_ff  <= issue_on_in;
         r_valid_ff   <= r_valid_in;
         p_valid_ff   <= p_valid_in;
         v_valid_ff   <= v_valid_in;
         peak_ff      <= peak_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign q_pop          = pop;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_found      = found_ff;
   assign rsp_left_edge  = left_edge_ff;
   assign rsp_right_edge = right_edge_ff;

endmodule

`default_nettype wire

/* rtl/column_spread_strip_bounds.sv */
// Column spread strip bounds: finds the left and right edge of the busy
// strip of a band of gray pixels. Top level; depends on csb_pkg,
// csb_front, csb_queue and csb_back (which holds csb_ram).
//
// Usage: load column_count (index 0) and row_count (index 1) through the
// csr_ port while the block is idle, then stream the band's pixels in
// row-major order on the req_ port, one beat per pixel. Each band yields
// exactly one beat on the rsp_ port with found, left_edge and right_edge.
// Throughput: one pixel per cycle while a band accumulates and the
// queue has room; every pixel does a read-modify-write of its column
// entry in the column RAM. The result follows the last pixel's beat
// after two scans over the column RAM, one column per cycle through
// its single read port, behind a three-stage variance pipeline. A
// four-entry queue keeps req_ready high for the first pixels of the
// next band during those scans.
// Reset clears positions, the peak and all handshakes; column RAM contents
// are not cleared. While rsp_ready is low, the finished result is held
// and the next band's pixels are still taken until its own scan ends.
`default_nettype none

module column_spread_strip_bounds
   import csb_pkg::*;
#(
   parameter int MAX_COLUMNS = DEFAULT_MAX_COLUMNS,
   parameter int MAX_ROWS    = DEFAULT_MAX_ROWS
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic [PIXEL_WIDTH-1:0]     req_pixel,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic                            rsp_found,
   output logic      [EDGE_WIDTH-1:0]      rsp_left_edge,
   output logic      [EDGE_WIDTH-1:0]      rsp_right_edge,
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   localparam int XW = $clog2(MAX_COLUMNS);
   localparam int CW = $clog2(MAX_COLUMNS + 1);
   localparam int HW = $clog2(MAX_ROWS + 1);
   localparam int EW = HW + 2 + XW + PIXEL_WIDTH;

   logic [CW-1:0] cols;
   logic          q_push;
   logic [EW-1:0] q_push_data;
   logic          q_full;
   logic          q_pop;
   logic [EW-1:0] q_pop_data;
   logic          q_empty;

   csb_front #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .MAX_ROWS    (MAX_ROWS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_pixel (req_pixel),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cols      (cols),
      .q_push    (q_push),
      .q_data    (q_push_data),
      .q_full    (q_full)
   );

   csb_queue #(
      .WIDTH (EW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .empty     (q_empty)
   );

   csb_back #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .MAX_ROWS    (MAX_ROWS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .cols           (cols),
      .q_data         (q_pop_data),
      .q_empty        (q_empty),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_found      (rsp_found),
      .rsp_left_edge  (rsp_left_edge),
      .rsp_right_edge (rsp_right_edge)
   );

endmodule

`default_nettype wire

/* test/column_spread_strip_bounds_tb.sv */
// Self-checking testbench for column_spread_strip_bounds: streams bands of pixels,
// predicts each band's strip bounds and compares every result beat.
// Depends on csb_pkg and the RTL of the block only.
`timescale 1ns / 100ps

module column_spread_strip_bounds_tb
   import csb_pkg::*;
();

   localparam int COLUMN_LIMIT   = DEFAULT_MAX_COLUMNS;
   localparam int ROW_LIMIT      = DEFAULT_MAX_ROWS;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int RANDOM_ITEMS   = 360;
   localparam int MIN_BANDS      = 1;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_LOW  = CSR_INDEX_WIDTH'(2);
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_HIGH = CSR_INDEX_WIDTH'(3);

   typedef enum {STYLE_FLAT, STYLE_FAINT, STYLE_NOISY, STYLE_EXTREME} column_style_type;

   typedef struct packed {
      logic                  found;
      logic [EDGE_WIDTH-1:0] left_edge;
      logic [EDGE_WIDTH-1:0] right_edge;
   } strip_bounds_type;

   class strip_board_type;
      int unsigned      column_reg;
      int unsigned      row_reg;
      int unsigned      column_sum [COLUMN_LIMIT];
      longint unsigned  square_sum [COLUMN_LIMIT];
      int unsigned      column_pos;
      int unsigned      row_pos;
      longint unsigned  peak_spread;
      bit               band_closed;
      int unsigned      pixels_seen;
      int unsigned      errors;
      strip_bounds_type expected_bounds [$];

      function new();
         column_reg  = COLUMN_COUNT_RESET;
         row_reg     = ROW_COUNT_RESET;
         column_pos  = 0;
         row_pos     = 0;
         peak_spread = 0;
         band_closed = 1'b0;
         pixels_seen = 0;
         errors      = 0;
         foreach (column_sum[x]) begin
            column_sum[x] = 0;
            square_sum[x] = 0;
         end
      endfunction

      function int unsigned clamp_count(int unsigned value, int unsigned high);
         if (value < 1) begin
            return 1;
         end
         if (value > high) begin
            return high;
         end
         return value;
      endfunction

      function int unsigned active_columns();
         return clamp_count(column_reg, COLUMN_LIMIT);
      endfunction

      function void note_config(logic [CSR_INDEX_WIDTH-1:0] index,
                                logic [CSR_DATA_WIDTH-1:0] data);
         case (index)
            CSR_COLUMN_COUNT: begin
               column_reg = data[COLUMN_COUNT_WIDTH-1:0];
            end
            CSR_ROW_COUNT: begin
               row_reg = data[ROW_COUNT_WIDTH-1:0];
            end
            default: begin
            end
         endcase
      endfunction

      function strip_bounds_type measure_band(int unsigned cols, int unsigned height);
         longint unsigned  spread [COLUMN_LIMIT];
         longint unsigned  s;
         longint unsigned  a;
         longint unsigned  b;
         longint unsigned  peak;
         int unsigned      x;
         int unsigned      left;
         int unsigned      right;
         int unsigned      flat;
         bit               have_left;
         strip_bounds_type bounds;
         peak      = 0;
         left      = 0;
         right     = 0;
         flat      = 0;
         have_left = 1'b0;
         for (x = 0; x < cols; x++) begin
            s = column_sum[x];
            a = longint'(height) * square_sum[x];
            b = s * s;
            spread[x] = (a > b) ? a - b : 0;
            if (spread[x] > peak) begin
               peak = spread[x];
            end
         end
         peak_spread = peak;
         if (peak > 0) begin
            for (x = 0; x < cols && !have_left; x++) begin
               if ((spread[x] << THRESHOLD_SHIFT) > peak) begin
                  left      = x;
                  have_left = 1'b1;
               end
            end
            if (have_left) begin
               right = left;
               for (x = left; x < cols && flat <= FLAT_RUN_TO_STOP; x++) begin
                  if ((spread[x] << THRESHOLD_SHIFT) > peak) begin
                     right = x;
                     flat  = 0;
                  end else begin
                     flat++;
                  end
               end
            end
         end
         bounds.found      = have_left && height >= MIN_BAND_ROWS && right > left;
         bounds.left_edge  = bounds.found ? EDGE_WIDTH'(left) : '0;
         bounds.right_edge = bounds.found ? EDGE_WIDTH'(right) : '0;
         return bounds;
      endfunction

      function void note_pixel(logic [PIXEL_WIDTH-1:0] pixel);
         int unsigned cols;
         int unsigned rows;
         int unsigned x;
         int unsigned done_rows;
         cols = clamp_count(column_reg, COLUMN_LIMIT);
         rows = clamp_count(row_reg, ROW_LIMIT);
         x    = column_pos;
         if (x >= COLUMN_LIMIT) begin
            x = COLUMN_LIMIT - 1;
         end
         if (row_pos == 0) begin
            column_sum[x] = pixel;
            square_sum[x] = longint'(pixel) * pixel;
         end else begin
            column_sum[x] += pixel;
            square_sum[x] += longint'(pixel) * pixel;
         end
         pixels_seen++;
         band_closed = 1'b0;
         if (x + 1 >= cols) begin
            done_rows  = row_pos + 1;
            column_pos = 0;
            if (done_rows >= rows) begin
               row_pos     = 0;
               band_closed = 1'b1;
               expected_bounds.insert(expected_bounds.size(), measure_band(cols, done_rows));
            end else begin
               row_pos = done_rows;
            end
         end else begin
            column_pos = x + 1;
         end
      endfunction

      function void check_bounds(logic found, logic [EDGE_WIDTH-1:0] left_edge,
                                 logic [EDGE_WIDTH-1:0] right_edge);
         strip_bounds_type want;
         if (expected_bounds.size() == 0) begin
            $error("unexpected result beat: found %0d, left_edge %0d, right_edge %0d",
                   found, left_edge, right_edge);
            errors++;
            return;
         end
         want = expected_bounds.pop_front();
         if (found !== want.found) begin
            $error("found: expected %0d, actual %0d", want.found, found);
            errors++;
         end
         if (left_edge !== want.left_edge) begin
            $error("left_edge: expected %0d, actual %0d", want.left_edge, left_edge);
            errors++;
         end
         if (right_edge !== want.right_edge) begin
            $error("right_edge: expected %0d, actual %0d", want.right_edge, right_edge);
            errors++;
         end
      endfunction
   endclass

   logic                       clock     = 1'b0;
   logic                       reset     = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [PIXEL_WIDTH-1:0]     req_pixel = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic                       rsp_found;
   logic [EDGE_WIDTH-1:0]      rsp_left_edge;
   logic [EDGE_WIDTH-1:0]      rsp_right_edge;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata = '0;

   int unsigned      send_idle_pct = 6;
   int unsigned      stall_pct     = 84;
   int unsigned      quiet_cycles  = 0;
   column_style_type column_style [COLUMN_LIMIT];
   logic [7:0]       column_base [COLUMN_LIMIT];
   strip_board_type  board = new();

   column_spread_strip_bounds u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_pixel      (req_pixel),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_found      (rsp_found),
      .rsp_left_edge  (rsp_left_edge),
      .rsp_right_edge (rsp_right_edge),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            board.check_bounds(rsp_found, rsp_left_edge, rsp_right_edge);
         end
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic void set_style(int lo, int hi, column_style_type style);
      int x;
      for (x = lo; x <= hi; x++) begin
         column_style[x] = style;
         column_base[x]  = 8'($urandom_range(250));
      end
   endfunction

   function automatic void plan_styles(int unsigned cols);
      int unsigned x;
      int unsigned r;
      int unsigned run_length;
      int unsigned run_start;
      for (x = 0; x < cols; x++) begin
         r = $urandom_range(99);
         if (r < 40) begin
            set_style(x, x, STYLE_FLAT);
         end else if (r < 60) begin
            set_style(x, x, STYLE_FAINT);
         end else if (r < 85) begin
            set_style(x, x, STYLE_NOISY);
         end else begin
            set_style(x, x, STYLE_EXTREME);
         end
      end
      // Wide bands get a long quiet stretch about half the time so the scan can stop early.
      if (cols >= 27 && $urandom_range(1) == 1) begin
         run_length = $urandom_range(20, 30);
         if (run_length > cols - 1) begin
            run_length = cols - 1;
         end
         run_start = $urandom_range(1, cols - run_length);
         set_style(run_start, run_start + run_length - 1, STYLE_FLAT);
      end
   endfunction

   function automatic logic [7:0] pick_pixel(int unsigned x);
      case (column_style[x])
         STYLE_FLAT: begin
            return column_base[x];
         end
         STYLE_FAINT: begin
            return column_base[x] + 8'($urandom_range(3));
         end
         STYLE_NOISY: begin
            return 8'($urandom_range(255));
         end
         default: begin
            return ($urandom_range(1) == 1) ? 8'd255 : 8'd0;
         end
      endcase
   endfunction

   task automatic write_register(logic [CSR_INDEX_WIDTH-1:0] index,
                                 logic [CSR_DATA_WIDTH-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      board.note_config(index, data);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_pixel(logic [PIXEL_WIDTH-1:0] pixel);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pixel <= pixel;
      do @(posedge clock); while (!req_ready);
      board.note_pixel(pixel);
   endtask

   task automatic send_run(int unsigned count);
      repeat (count) begin
         send_pixel(pick_pixel(board.column_pos));
      end
   endtask

   task automatic send_band();
      do begin
         send_pixel(pick_pixel(board.column_pos));
      end while (!board.band_closed);
   endtask

   // Holds the input until every pending result beat has drained and the
   // block has had time to finish any column scan still in flight.
   task automatic drain();
      int unsigned settle_cycles;
      req_valid <= 1'b0;
      while (board.expected_bounds.size() != 0) begin
         @(posedge clock);
      end
      settle_cycles = 2 * board.active_columns() + 20;
      repeat (settle_cycles) @(posedge clock);
   endtask

   task automatic run_random(int unsigned idle_pct, int unsigned stall, int unsigned item_goal);
      int unsigned first_pixel;
      int unsigned bands;
      int unsigned cols;
      int unsigned rows;
      int unsigned group;
      int unsigned r;
      send_idle_pct = idle_pct;
      stall_pct     = stall;
      first_pixel   = board.pixels_seen;
      bands         = 0;
      while (board.pixels_seen - first_pixel < item_goal || bands < MIN_BANDS) begin
         r = $urandom_range(99);
         if (r < 8) begin
            cols = 1;
         end else if (r < 90) begin
            cols = $urandom_range(2, 6);
         end else if (r < 97) begin
            cols = $urandom_range(7, 16);
         end else begin
            cols = $urandom_range(27, 36);
         end
         r = $urandom_range(99);
         if (r < 75) begin
            rows = $urandom_range(20, 22);
         end else if (r < 88) begin
            rows = $urandom_range(1, 19);
         end else if (r < 98) begin
            rows = $urandom_range(23, 30);
         end else begin
            rows = 0;
         end
         write_register(CSR_COLUMN_COUNT, CSR_DATA_WIDTH'(cols));
         write_register(CSR_ROW_COUNT, CSR_DATA_WIDTH'(rows));
         group = $urandom_range(1, 3);
         repeat (group) begin
            plan_styles(cols);
            if ($urandom_range(19) == 0) begin
               send_run($urandom_range(1, 2 * cols));
               drain();
               write_register(CSR_COLUMN_COUNT, CSR_DATA_WIDTH'($urandom_range(1, cols)));
               write_register(CSR_ROW_COUNT, CSR_DATA_WIDTH'($urandom_range(1, 30)));
            end
            send_band();
         end
         bands += group;
         drain();
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Counts of zero act as one, so this band is a single pixel.
      write_register(CSR_COLUMN_COUNT, '0);
      write_register(CSR_ROW_COUNT, '0);
      write_register(CSR_SPARE_LOW, CSR_DATA_WIDTH'($urandom_range(2047)));
      write_register(CSR_SPARE_HIGH, '1);
      set_style(0, 0, STYLE_NOISY);
      send_band();
      drain();

      // The tallest band, with a row count above the limit.
      write_register(CSR_COLUMN_COUNT, CSR_DATA_WIDTH'(1));
      write_register(CSR_ROW_COUNT, '1);
      set_style(0, 0, STYLE_EXTREME);
      send_band();
      drain();

      // A flat run one longer than the stop length.
      write_register(CSR_COLUMN_COUNT, CSR_DATA_WIDTH'(30));
      write_register(CSR_ROW_COUNT, CSR_DATA_WIDTH'(MIN_BAND_ROWS));
      set_style(0, 1, STYLE_NOISY);
      set_style(2, 27, STYLE_FLAT);
      set_style(28, 29, STYLE_NOISY);
      send_band();
      drain();

      write_register(CSR_COLUMN_COUNT, CSR_DATA_WIDTH'(3));
      write_register(CSR_ROW_COUNT, CSR_DATA_WIDTH'(MIN_BAND_ROWS - 1));
      set_style(0, 2, STYLE_NOISY);
      send_band();
      drain();
      write_register(CSR_ROW_COUNT, CSR_DATA_WIDTH'(MIN_BAND_ROWS));
      set_style(0, 2, STYLE_FLAT);
      send_band();
      set_style(0, 2, STYLE_NOISY);
      send_band();
      drain();

      write_register(CSR_COLUMN_COUNT, CSR_DATA_WIDTH'(1));
      send_band();
      drain();

      // Widening mid-band leaves stale sums from the previous band in the new columns.
      write_register(CSR_COLUMN_COUNT, CSR_DATA_WIDTH'(4));
      plan_styles(4);
      send_band();
      drain();
      write_register(CSR_COLUMN_COUNT, CSR_DATA_WIDTH'(2));
      send_run(4);
      drain();
      write_register(CSR_COLUMN_COUNT, CSR_DATA_WIDTH'(4));
      send_band();
      drain();

      write_register(CSR_COLUMN_COUNT, CSR_DATA_WIDTH'(3));
      write_register(CSR_ROW_COUNT, CSR_DATA_WIDTH'(40));
      plan_styles(3);
      send_run(75);
      drain();
      write_register(CSR_ROW_COUNT, CSR_DATA_WIDTH'(22));
      send_band();
      drain();

      write_register(CSR_COLUMN_COUNT, CSR_DATA_WIDTH'(6));
      write_register(CSR_ROW_COUNT, CSR_DATA_WIDTH'(MIN_BAND_ROWS));
      plan_styles(6);
      send_run(3);
      drain();
      write_register(CSR_COLUMN_COUNT, CSR_DATA_WIDTH'(2));
      send_band();
      drain();

      run_random(6, 84, RANDOM_ITEMS / 3);
      run_random(84, 6, RANDOM_ITEMS / 3);
      run_random(0, 0, RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
      drain();

      if (board.errors == 0 && board.expected_bounds.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/csb_pkg.sv
rtl/csb_ram.sv
rtl/csb_queue.sv
rtl/csb_front.sv
rtl/csb_back.sv
rtl/column_spread_strip_bounds.sv
test/column_spread_strip_bounds_tb.sv
